/* src/ppp_pkg.sv */
package ppp_pkg;

    // Matrix store: rows 0, 1 and 3 of the view matrix, four columns each.
    localparam int ENTRIES = 12;
    localparam int COLS    = 4;
    localparam int ROWS    = 3;

    // Datapath widths.
    localparam int Q_W     = 32;   // Q16.16 word
    localparam int FRAC_W  = 16;   // fractional bits
    localparam int PROD_W  = 48;   // floored entry * coordinate product
    localparam int SUM_W   = 50;   // dot product sum
    localparam int MAG_W   = 49;   // magnitude of a dot product
    localparam int NUM_W   = 64;   // scale * magnitude
    localparam int DEN_W   = 50;   // 2 * |w|
    localparam int QUO_W   = 40;   // quotient bits produced by the divider
    localparam int HI_W    = NUM_W - (QUO_W - FRAC_W);
    localparam int DIV_LAT = QUO_W + 1;
    localparam int SCALE_W = 15;
    localparam int FIFO_DEPTH = 2;

    localparam logic signed [Q_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [SUM_W-1:0] HALF_PIX = SUM_W'(32768);

    // Configuration register indexes.
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic {
        REQ_LOAD    = 1'b0,
        REQ_PROJECT = 1'b1
    } t_req;

    typedef struct packed {
        t_req                  req;
        logic [3:0]            idx;
        logic signed [Q_W-1:0] value;
        logic signed [Q_W-1:0] x;
        logic signed [Q_W-1:0] y;
        logic signed [Q_W-1:0] z;
    } t_op;

    // Per-item flags carried alongside the dividers.
    typedef struct packed {
        logic                  wz;
        logic                  cx_neg;
        logic                  cy_neg;
        logic signed [Q_W-1:0] dw;
    } t_side;

    // Saturate a wide signed value to the signed 32 bit range.
    function automatic logic signed [Q_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-Q_W:0] top;
        top = v[SUM_W-1:Q_W-1];
        if (top == '0 || top == '1) begin
            return v[Q_W-1:0];
        end else if (v[SUM_W-1]) begin
            return S32_MIN;
        end else begin
            return S32_MAX;
        end
    endfunction

endpackage

/* src/ppp_front.sv */
module ppp_front import ppp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_full,
    input  t_op  i_op,
    output logic o_fifo_push,
    output t_op  o_fifo_op,
    input  logic i_fifo_full
);

    logic r_valid;
    logic n_valid;
    t_op  r_op;
    logic w_drop;
    logic w_leave;
    logic w_acc;

    // Loads to entries outside the store are dropped here.
    assign w_drop  = (r_op.req == REQ_LOAD) && (r_op.idx >= 4'(ENTRIES));
    assign w_leave = r_valid && (w_drop || !i_fifo_full);
    assign o_full  = r_valid && !w_leave;
    assign w_acc   = i_push && !o_full;

    assign o_fifo_push = r_valid && !w_drop && !i_fifo_full;
    assign o_fifo_op   = r_op;

    // Input stage holds one item until the queue takes it.
    always_comb begin
        n_valid = w_acc || (r_valid && !w_leave);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_op <= i_op;
        end
    end

endmodule

/* src/ppp_fifo.sv */
module ppp_fifo import ppp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    input  logic i_pop,
    output t_op  o_op,
    output logic o_empty
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    t_op              r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_cnt;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [PTR_W:0]   n_cnt;
    logic             w_wr_en;
    logic             w_rd_en;

    assign o_full  = (r_cnt == (PTR_W+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_op    = r_mem[r_rd];
    assign w_wr_en = i_push && !o_full;
    assign w_rd_en = i_pop && !o_empty;

    // Pointer and count update.
    always_comb begin
        n_wr  = w_wr_en ? PTR_W'(r_wr + 1'b1) : r_wr;
        n_rd  = w_rd_en ? PTR_W'(r_rd + 1'b1) : r_rd;
        n_cnt = r_cnt + (PTR_W+1)'(w_wr_en) - (PTR_W+1)'(w_rd_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_op;
        end
    end

endmodule

/* src/ppp_div.sv */
module ppp_div import ppp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic             i_neg,
    output logic [QUO_W:0]   o_mag,
    output logic             o_neg
);

    logic [DEN_W-1:0] r_rem [QUO_W+1];
    logic [QUO_W-1:0] r_quo [QUO_W+1];
    logic [DEN_W-1:0] r_den [QUO_W+1];
    logic             r_ovf [QUO_W+1];
    logic             r_neg [QUO_W+1];
    logic [DEN_W-1:0] w_hi;

    // Entry stage: the upper numerator bits seed the remainder; a quotient
    // that would not fit in 40 bits is flagged and capped at the output.
    assign w_hi = {{(DEN_W-HI_W){1'b0}}, i_num[NUM_W-1 -: HI_W]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_hi;
            r_quo[0] <= {i_num[NUM_W-HI_W-1:0], {FRAC_W{1'b0}}};
            r_den[0] <= i_den;
            r_ovf[0] <= (w_hi >= i_den);
            r_neg[0] <= i_neg;
        end
    end

    // One restoring step per stage; numerator bits shift out of the top of
    // the quotient register as quotient bits shift in at the bottom.
    for (genvar s = 0; s < QUO_W; s++) begin : g_step
        logic [DEN_W:0] w_shift;
        logic [DEN_W:0] w_diff;
        logic           w_ge;

        assign w_shift = {r_rem[s], r_quo[s][QUO_W-1]};
        assign w_diff  = w_shift - {1'b0, r_den[s]};
        assign w_ge    = (w_shift >= {1'b0, r_den[s]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= w_ge ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
                r_quo[s+1] <= {r_quo[s][QUO_W-2:0], w_ge};
                r_den[s+1] <= r_den[s];
                r_ovf[s+1] <= r_ovf[s];
                r_neg[s+1] <= r_neg[s];
            end
        end
    end

    assign o_mag = r_ovf[QUO_W] ? {1'b1, {QUO_W{1'b0}}} : {1'b0, r_quo[QUO_W]};
    assign o_neg = r_neg[QUO_W];

endmodule

/* src/ppp_back.sv */
module ppp_back import ppp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fifo_empty,
    input  t_op                   i_fifo_op,
    output logic                  o_fifo_pop,
    input  logic [SCALE_W-1:0]    i_width,
    input  logic [SCALE_W-1:0]    i_height,
    input  logic                  i_pop,
    output logic                  o_empty,
    output logic signed [Q_W-1:0] o_screen_x,
    output logic signed [Q_W-1:0] o_screen_y,
    output logic signed [Q_W-1:0] o_depth_w,
    output logic                  o_in_bounds,
    output logic                  o_w_zero
);

    localparam int OFF_W = QUO_W + 2;

    logic                  w_en;
    logic                  w_take;
    logic signed [Q_W-1:0] r_mat [ENTRIES];
    logic signed [Q_W-1:0] w_pt [3];

    logic                    r_v0;
    logic signed [PROD_W-1:0] r_prod [ROWS][3];
    logic signed [Q_W-1:0]    r_bias [ROWS];
    logic                    r_v1;
    logic signed [SUM_W-1:0] r_sum [ROWS];
    logic                    r_v2;
    logic [NUM_W-1:0]        r_num_x;
    logic [NUM_W-1:0]        r_num_y;
    logic [DEN_W-1:0]        r_den;
    logic                    r_neg_x;
    logic                    r_neg_y;
    t_side                   r_side2;
    logic                    r_vpipe [DIV_LAT];
    t_side                   r_spipe [DIV_LAT];

    logic [MAG_W-1:0] w_mag [ROWS];
    logic [QUO_W:0]   w_qx;
    logic [QUO_W:0]   w_qy;
    logic             w_nx;
    logic             w_ny;
    t_side            w_side;

    logic signed [SUM_W-1:0] w_off_x;
    logic signed [SUM_W-1:0] w_off_y;
    logic signed [SUM_W-1:0] w_sx_full;
    logic signed [SUM_W-1:0] w_sy_full;
    logic signed [Q_W-1:0]   w_sx;
    logic signed [Q_W-1:0]   w_sy;
    logic                    w_inb;

    logic                  r_out_valid;
    logic signed [Q_W-1:0] r_sx;
    logic signed [Q_W-1:0] r_sy;
    logic signed [Q_W-1:0] r_dw;
    logic                  r_inb;
    logic                  r_wz;

    // The whole back pipeline advances unless the output item is stuck.
    assign w_en       = !r_out_valid || i_pop;
    assign w_take     = w_en && !i_fifo_empty;
    assign o_fifo_pop = w_take;

    assign w_pt[0] = i_fifo_op.x;
    assign w_pt[1] = i_fifo_op.y;
    assign w_pt[2] = i_fifo_op.z;

    // Matrix store, written in item order so projects see earlier loads.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_mat[i] <= '0;
            end
        end else if (w_take && i_fifo_op.req == REQ_LOAD) begin
            r_mat[i_fifo_op.idx] <= i_fifo_op.value;
        end
    end

    // Stage 0: nine products, each floored to Q32.16 (48 bits).
    for (genvar r = 0; r < ROWS; r++) begin : g_row
        for (genvar c = 0; c < 3; c++) begin : g_col
            logic signed [2*Q_W-1:0] w_p;
            assign w_p = (2*Q_W)'(r_mat[r*COLS+c]) * (2*Q_W)'(w_pt[c]);
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_prod[r][c] <= w_p[2*Q_W-1:FRAC_W];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_bias[r] <= r_mat[r*COLS+3];
                r_sum[r]  <= SUM_W'(r_prod[r][0]) + SUM_W'(r_prod[r][1])
                           + SUM_W'(r_prod[r][2]) + SUM_W'(r_bias[r]);
            end
        end
        assign w_mag[r] = r_sum[r][SUM_W-1] ? MAG_W'(-r_sum[r]) : MAG_W'(r_sum[r]);
    end

    // Stage 2: scaled numerators, divisor and sign flags.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num_x        <= NUM_W'(i_width) * NUM_W'(w_mag[0]);
            r_num_y        <= NUM_W'(i_height) * NUM_W'(w_mag[1]);
            r_den          <= {w_mag[2], 1'b0};
            r_neg_x        <= r_sum[0][SUM_W-1] ^ r_sum[2][SUM_W-1];
            r_neg_y        <= r_sum[1][SUM_W-1] ^ r_sum[2][SUM_W-1];
            r_side2.wz     <= (r_sum[2] == '0);
            r_side2.cx_neg <= r_sum[0][SUM_W-1];
            r_side2.cy_neg <= r_sum[1][SUM_W-1];
            r_side2.dw     <= sat32(r_sum[2]);
        end
    end

    ppp_div u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_num_x),
        .i_den (r_den),
        .i_neg (r_neg_x),
        .o_mag (w_qx),
        .o_neg (w_nx)
    );

    ppp_div u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_num_y),
        .i_den (r_den),
        .i_neg (r_neg_y),
        .o_mag (w_qy),
        .o_neg (w_ny)
    );

    // Valid bits through the front stages and alongside the dividers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++) begin
                r_vpipe[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_v0 <= w_take && (i_fifo_op.req == REQ_PROJECT);
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_vpipe[0] <= r_v2;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_vpipe[i] <= r_vpipe[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_spipe[0] <= r_side2;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_spipe[i] <= r_spipe[i-1];
            end
        end
    end

    assign w_side = r_spipe[DIV_LAT-1];

    // Pixel mapping: centre plus signed offset, half-pixel bias, y inverted; a zero w saturates, out of bounds.
    always_comb begin
        w_off_x   = w_nx ? -SUM_W'(w_qx) : SUM_W'(w_qx);
        w_off_y   = w_ny ? -SUM_W'(w_qy) : SUM_W'(w_qy);
        w_sx_full = signed'(SUM_W'({i_width, 15'd0})) + w_off_x + HALF_PIX;
        w_sy_full = signed'(SUM_W'({i_height, 15'd0})) - (w_off_y + HALF_PIX);
        w_sx      = sat32(w_sx_full);
        w_sy      = sat32(w_sy_full);
        w_inb     = (w_sx >= 0) && (w_sx <= signed'({1'b0, i_width, 16'd0}))
                 && (w_sy >= 0) && (w_sy <= signed'({1'b0, i_height, 16'd0}));
        if (w_side.wz) begin
            w_sx  = w_side.cx_neg ? S32_MIN : S32_MAX;
            w_sy  = w_side.cy_neg ? S32_MAX : S32_MIN;
            w_inb = 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_vpipe[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sx  <= w_sx;
            r_sy  <= w_sy;
            r_dw  <= w_side.dw;
            r_inb <= w_inb;
            r_wz  <= w_side.wz;
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_screen_x  = r_sx;
    assign o_screen_y  = r_sy;
    assign o_depth_w   = r_dw;
    assign o_in_bounds = r_inb;
    assign o_w_zero    = r_wz;

endmodule

/* src/perspective_point_projection.sv */
// Channel   Direction  Handshake          Payload
// input     in         push / full        req_type, entry_index, entry_value, point_x/y/z
// result    out        empty / pop        screen_x, screen_y, depth_w, in_bounds, w_zero
// config    in         APB psel/penable   screen_width (0x0), screen_height (0x4)
//
// One item is taken per cycle while full is low. A project item passes the input
// stage, queue, product, sum and scale stages, then two 41-stage pipelined dividers
// (an entry stage, then one quotient bit per stage) and the output register.
// Reset clears the matrix, the queue and all valid bits, and loads 1920 x 1080.
// A held result stalls the whole back pipeline; the queue and input stage then
// fill, and full rises once they hold three items between them.
module perspective_point_projection import ppp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  i_req_type,
    input  logic [3:0]            i_entry_index,
    input  logic signed [Q_W-1:0] i_entry_value,
    input  logic signed [Q_W-1:0] i_point_x,
    input  logic signed [Q_W-1:0] i_point_y,
    input  logic signed [Q_W-1:0] i_point_z,
    output logic                  empty,
    input  logic                  pop,
    output logic signed [Q_W-1:0] o_screen_x,
    output logic signed [Q_W-1:0] o_screen_y,
    output logic signed [Q_W-1:0] o_depth_w,
    output logic                  o_in_bounds,
    output logic                  o_w_zero,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [SCALE_W-1:0] r_width;
    logic [SCALE_W-1:0] r_height;
    logic               w_cfg_wr;
    t_op                w_in_op;
    t_op                w_q_in;
    t_op                w_q_out;
    logic               w_q_push;
    logic               w_q_full;
    logic               w_q_pop;
    logic               w_q_empty;

    // Configuration registers.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SCALE_W'(1920);
            r_height <= SCALE_W'(1080);
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_WIDTH:  r_width  <= pwdata[SCALE_W-1:0];
                REG_HEIGHT: r_height <= pwdata[SCALE_W-1:0];
                default:    r_width  <= r_width;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WIDTH:  prdata = 32'(r_width);
            REG_HEIGHT: prdata = 32'(r_height);
            default:    prdata = '0;
        endcase
    end

    assign w_in_op.req   = t_req'(i_req_type);
    assign w_in_op.idx   = i_entry_index;
    assign w_in_op.value = i_entry_value;
    assign w_in_op.x     = i_point_x;
    assign w_in_op.y     = i_point_y;
    assign w_in_op.z     = i_point_z;

    ppp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_op        (w_in_op),
        .o_fifo_push (w_q_push),
        .o_fifo_op   (w_q_in),
        .i_fifo_full (w_q_full)
    );

    ppp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_op    (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_op    (w_q_out),
        .o_empty (w_q_empty)
    );

    ppp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fifo_empty (w_q_empty),
        .i_fifo_op    (w_q_out),
        .o_fifo_pop   (w_q_pop),
        .i_width      (r_width),
        .i_height     (r_height),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_screen_x   (o_screen_x),
        .o_screen_y   (o_screen_y),
        .o_depth_w    (o_depth_w),
        .o_in_bounds  (o_in_bounds),
        .o_w_zero     (o_w_zero)
    );

endmodule
